### sv/aechi_pkg.sv
// ----------------------------------------------------------------------------
// aechi_pkg: shared types and constants for the ACPI EC host interface
// Command codes, item and result layouts, event ring sizing and helpers.
// ----------------------------------------------------------------------------
package aechi_pkg;

	// event ring sizing (one slot always stays free)
	localparam int QUEUE_DEPTH = 16;
	localparam int QIDX_W      = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;

	// ec space
	localparam int EC_DEPTH  = 256;
	localparam int EC_ADDR_W = 8;

	// configuration port
	localparam int  PADDR_W     = 3;
	localparam int  PDATA_W     = 32;
	localparam logic REG_ACPI_EN = 1'b0;

	// host command codes
	localparam logic [7:0] CMD_READ      = 8'h80;
	localparam logic [7:0] CMD_WRITE     = 8'h81;
	localparam logic [7:0] CMD_BURST_ON  = 8'h82;
	localparam logic [7:0] CMD_BURST_OFF = 8'h83;
	localparam logic [7:0] CMD_QUERY     = 8'h84;
	localparam logic [7:0] BURST_ACK     = 8'h90;

	// data bytes that follow a read or write command
	localparam logic [1:0] BYTES_READ  = 2'h1;
	localparam logic [1:0] BYTES_WRITE = 2'h2;

	typedef enum logic [1:0] {
		OP_COMMAND = 2'd0,
		OP_DATA    = 2'd1,
		OP_EVENT   = 2'd2,
		OP_TIMEOUT = 2'd3
	} opcode_t;

	typedef struct packed {
		opcode_t    opcode;
		logic [7:0] byte_value;
		logic       host_awake;
	} item_t;

	typedef struct packed {
		logic       reply_valid;
		logic [7:0] reply_byte;
		logic       sci_pulse;
		logic       event_pending;
		logic       burst_active;
		logic       burst_watch;
	} result_t;

	function automatic logic [QIDX_W-1:0] qnext(input logic [QIDX_W-1:0] idx);
		logic [QIDX_W-1:0] res;
		if (idx == QIDX_W'(QUEUE_DEPTH - 1)) begin
			res = '0;
		end else begin
			res = idx + QIDX_W'(1);
		end
		return res;
	endfunction

endpackage

### sv/aechi_ram.sv
// ----------------------------------------------------------------------------
// aechi_ram: generic single-write, single-read RAM
// One write port and one read port with registered read data and read enable.
// ----------------------------------------------------------------------------
module aechi_ram #(
	parameter int WIDTH = 8,
	parameter int DEPTH = 256
) (
	input  logic                     clk,
	input  logic                     wr_en,
	input  logic [$clog2(DEPTH)-1:0] wr_addr,
	input  logic [WIDTH-1:0]         wr_data,
	input  logic                     rd_en,
	input  logic [$clog2(DEPTH)-1:0] rd_addr,
	output logic [WIDTH-1:0]         rd_data
);

	logic [WIDTH-1:0] mem_q [DEPTH];

	always_ff @(posedge clk) begin
		if (wr_en) begin
			mem_q[wr_addr] <= wr_data;
		end
		if (rd_en) begin
			rd_data <= mem_q[rd_addr];
		end
	end

endmodule

### sv/acpi_ec_host_interface.sv
// ----------------------------------------------------------------------------
// acpi_ec_host_interface: host side of an ACPI embedded controller
// Decodes host command and data bytes, event pushes and burst timeouts.
// ----------------------------------------------------------------------------
// Usage:
//   cmd channel (cmd_valid / cmd_stall / cmd) carries one host item: a command
//   byte, a data byte, a firmware event push or a burst timeout.
//   res channel (res_valid / res_stall / res) returns exactly one result per
//   item, in order: optional reply byte, sci pulse and the status bits.
//   The acpi enable register sits on the apb port at byte address 0.
// Timing:
//   an item is registered on entry, decoded against the ec space ram
//   (registered read, address taken from the item on entry) and lands in
//   the result register: res_valid rises once it moves there from the entry register.
//   One item per cycle is sustained while res_stall is low; the result
//   register and the entry register let a new item in while a result waits.
// Reset:
//   all status, command state, ring pointers and the ec space valid bits
//   clear at once, so the ec space reads as zeros with no clearing pass.
// Stall:
//   with res_stall high the result holds; the entry register then fills and
//   cmd_stall rises one item later.
// ----------------------------------------------------------------------------
module acpi_ec_host_interface
	import aechi_pkg::*;
(
	input  logic               clk,
	input  logic               arst_n,
	// host item channel
	input  logic               cmd_valid,
	output logic               cmd_stall,
	input  item_t              cmd,
	// result channel
	output logic               res_valid,
	input  logic               res_stall,
	output result_t            res,
	// configuration
	input  logic               psel,
	input  logic               penable,
	input  logic               pwrite,
	input  logic [PADDR_W-1:0] paddr,
	input  logic [PDATA_W-1:0] pwdata,
	output logic [PDATA_W-1:0] prdata,
	output logic               pready
);

	logic in_fire;
	logic s2_free;
	logic step;

	logic  valid_s1;
	item_t item_s1;
	logic  valid_s2;
	result_t res_s2;

	logic acpi_en_q;

	// command and burst state
	logic [7:0]          current_command_q, current_command_nxt;
	logic [1:0]          bytes_expected_q, bytes_expected_nxt;
	logic [7:0]          write_address_q, write_address_nxt;
	logic                pending_q, pending_nxt;
	logic                burst_q, burst_nxt;
	logic                watch_q, watch_nxt;

	// event ring
	logic [7:0]          queue_q [QUEUE_DEPTH];
	logic [QIDX_W-1:0]   head_q, head_nxt;
	logic [QIDX_W-1:0]   tail_q, tail_nxt;
	logic [QIDX_W-1:0]   head_inc;
	logic                q_wr;

	// ec space
	logic [EC_DEPTH-1:0]  ec_valid_q;
	logic                 ec_wr;
	logic                 ram_wr_en;
	logic [7:0]           ram_rd_data;
	logic                 bypass_q;
	logic [EC_ADDR_W-1:0] byp_addr_q;
	logic [7:0]           byp_data_q;
	logic [7:0]           ec_rd_byte;

	result_t res_nxt;

	// handshake
	assign s2_free   = !valid_s2 || !res_stall;
	assign cmd_stall = valid_s1 && !s2_free;
	assign in_fire   = cmd_valid && !cmd_stall;
	assign step      = valid_s1 && s2_free;
	assign res_valid = valid_s2;
	assign res       = res_s2;

	// configuration port
	assign pready = 1'b1;
	assign prdata = (paddr[2] == REG_ACPI_EN) ? PDATA_W'(acpi_en_q) : '0;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			acpi_en_q <= 1'b0;
		end else if (psel && penable && pwrite && pready && paddr[2] == REG_ACPI_EN) begin
			acpi_en_q <= pwdata[0];
		end
	end

	// entry register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (in_fire) begin
			valid_s1 <= 1'b1;
		end else if (step) begin
			valid_s1 <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (in_fire) begin
			item_s1 <= cmd;
		end
	end

	// ec space ram, read address taken straight from the incoming item
	assign ram_wr_en = step && ec_wr;

	aechi_ram #(
		.WIDTH (8),
		.DEPTH (EC_DEPTH)
	) u_ec_ram (
		.clk     (clk),
		.wr_en   (ram_wr_en),
		.wr_addr (write_address_q),
		.wr_data (item_s1.byte_value),
		.rd_en   (in_fire),
		.rd_addr (cmd.byte_value),
		.rd_data (ram_rd_data)
	);

	// bypass covers a write made on the same edge the reading item entered
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			bypass_q   <= 1'b0;
			ec_valid_q <= '0;
		end else begin
			if (in_fire) begin
				bypass_q <= ram_wr_en;
			end
			if (ram_wr_en) begin
				ec_valid_q[write_address_q] <= 1'b1;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (ram_wr_en) begin
			byp_addr_q <= write_address_q;
			byp_data_q <= item_s1.byte_value;
		end
	end

	always_comb begin
		if (!ec_valid_q[item_s1.byte_value]) begin
			ec_rd_byte = '0;
		end else if (bypass_q && byp_addr_q == item_s1.byte_value) begin
			ec_rd_byte = byp_data_q;
		end else begin
			ec_rd_byte = ram_rd_data;
		end
	end

	assign head_inc = qnext(head_q);

	// item decode
	always_comb begin
		current_command_nxt = current_command_q;
		bytes_expected_nxt  = bytes_expected_q;
		write_address_nxt   = write_address_q;
		pending_nxt         = pending_q;
		burst_nxt           = burst_q;
		watch_nxt           = watch_q;
		head_nxt            = head_q;
		tail_nxt            = tail_q;
		q_wr                = 1'b0;
		ec_wr               = 1'b0;
		res_nxt             = '0;

		unique case (item_s1.opcode)
			OP_COMMAND: begin
				current_command_nxt = item_s1.byte_value;
				bytes_expected_nxt  = '0;
				unique case (item_s1.byte_value) inside
					CMD_READ, CMD_WRITE: begin
						res_nxt.sci_pulse  = 1'b1;
						bytes_expected_nxt = (item_s1.byte_value == CMD_READ) ?
							BYTES_READ : BYTES_WRITE;
						if (acpi_en_q && !burst_q) begin
							watch_nxt = 1'b1;
						end
					end
					CMD_BURST_ON: begin
						burst_nxt          = 1'b1;
						watch_nxt          = 1'b1;
						res_nxt.reply_valid = 1'b1;
						res_nxt.reply_byte  = BURST_ACK;
						res_nxt.sci_pulse   = 1'b1;
					end
					CMD_BURST_OFF: begin
						burst_nxt         = 1'b0;
						watch_nxt         = 1'b0;
						res_nxt.sci_pulse = 1'b1;
					end
					CMD_QUERY: begin
						if (head_q != tail_q) begin
							res_nxt.reply_valid = 1'b1;
							res_nxt.reply_byte  = queue_q[tail_q];
							res_nxt.sci_pulse   = 1'b1;
							tail_nxt            = qnext(tail_q);
							if (tail_nxt == head_q) begin
								pending_nxt = 1'b0;
							end
						end else begin
							pending_nxt = 1'b0;
						end
					end
					default: begin
					end
				endcase
			end
			OP_DATA: begin
				if (bytes_expected_q != '0) begin
					bytes_expected_nxt = bytes_expected_q - 2'd1;
					if (current_command_q == CMD_READ) begin
						if (bytes_expected_nxt == '0) begin
							res_nxt.reply_valid = 1'b1;
							res_nxt.reply_byte  = ec_rd_byte;
							res_nxt.sci_pulse   = 1'b1;
							watch_nxt           = 1'b0;
						end
					end else if (current_command_q == CMD_WRITE) begin
						res_nxt.sci_pulse = 1'b1;
						if (bytes_expected_nxt == BYTES_READ) begin
							// first byte after the write command is the address
							write_address_nxt = item_s1.byte_value;
						end else if (bytes_expected_nxt == '0) begin
							ec_wr     = 1'b1;
							watch_nxt = 1'b0;
						end
					end
				end
			end
			OP_EVENT: begin
				q_wr = 1'b1;
				// full ring: entry is overwritten in the free slot, head stays
				if (head_inc != tail_q) begin
					head_nxt = head_inc;
				end
				if (item_s1.host_awake) begin
					pending_nxt       = 1'b1;
					res_nxt.sci_pulse = 1'b1;
				end
			end
			OP_TIMEOUT: begin
				if (burst_q || watch_q) begin
					burst_nxt         = 1'b0;
					watch_nxt         = 1'b0;
					res_nxt.sci_pulse = 1'b1;
				end
			end
			default: begin
			end
		endcase

		res_nxt.event_pending = pending_nxt;
		res_nxt.burst_active  = burst_nxt;
		res_nxt.burst_watch   = watch_nxt;
	end

	// state update
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			current_command_q <= '0;
			bytes_expected_q  <= '0;
			write_address_q   <= '0;
			pending_q         <= 1'b0;
			burst_q           <= 1'b0;
			watch_q           <= 1'b0;
			head_q            <= '0;
			tail_q            <= '0;
		end else if (step) begin
			current_command_q <= current_command_nxt;
			bytes_expected_q  <= bytes_expected_nxt;
			write_address_q   <= write_address_nxt;
			pending_q         <= pending_nxt;
			burst_q           <= burst_nxt;
			watch_q           <= watch_nxt;
			head_q            <= head_nxt;
			tail_q            <= tail_nxt;
		end
	end

	always_ff @(posedge clk) begin
		if (step && q_wr) begin
			queue_q[head_q] <= item_s1.byte_value;
		end
	end

	// result register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s2 <= 1'b0;
		end else if (step) begin
			valid_s2 <= 1'b1;
		end else if (!res_stall) begin
			valid_s2 <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (step) begin
			res_s2 <= res_nxt;
		end
	end

endmodule

### sv/aechi_checker.sv
// ----------------------------------------------------------------------------
// aechi_checker: port-level checks for the ACPI EC host interface
// Watches the item and result channels and is bound to the top level.
// ----------------------------------------------------------------------------
module aechi_checker
	import aechi_pkg::*;
(
	input logic    clk,
	input logic    arst_n,
	input logic    cmd_stall,
	input logic    res_valid,
	input logic    res_stall,
	input result_t res
);

	// a held result stays put
	a_res_hold: assert property (@(posedge clk) disable iff (!arst_n)
		res_valid && res_stall |=> res_valid && $stable(res))
		else $error("result changed while stalled");

	// every reply byte comes with an sci pulse
	a_reply_sci: assert property (@(posedge clk) disable iff (!arst_n)
		res_valid && res.reply_valid |-> res.sci_pulse)
		else $error("reply without sci pulse");

	// no reply means a zero reply byte
	a_reply_zero: assert property (@(posedge clk) disable iff (!arst_n)
		res_valid && !res.reply_valid |-> res.reply_byte == 8'h00)
		else $error("reply byte set without reply");

	// an empty result register never backs up the item side
	a_no_false_stall: assert property (@(posedge clk) disable iff (!arst_n)
		!res_valid |-> !cmd_stall)
		else $error("item side stalled with result register empty");

endmodule

bind acpi_ec_host_interface aechi_checker u_aechi_checker (
	.clk       (clk),
	.arst_n    (arst_n),
	.cmd_stall (cmd_stall),
	.res_valid (res_valid),
	.res_stall (res_stall),
	.res       (res)
);

### tb/tb_acpi_ec_host_interface.sv
// ----------------------------------------------------------------------------
// tb_acpi_ec_host_interface: self-checking bench for the ACPI EC host port
// Drives host commands, data bytes, event pushes and burst timeouts with
// random pacing and result stalls, predicts every result in a scoreboard
// and compares it field by field. acpi enable is switched between phases.
// ----------------------------------------------------------------------------
module tb_acpi_ec_host_interface;
	timeunit 1ns;
	timeprecision 1ps;

	import aechi_pkg::*;

	localparam int WATCHDOG_LIMIT = 2000;

	// predicts the host-visible result of each item and holds those still due
	class host_scoreboard;
		bit         acpi_en;
		logic [7:0] cur_cmd;
		logic [1:0] byte_count;
		logic [7:0] wr_addr;
		logic [7:0] ec_mem [EC_DEPTH];
		logic [7:0] ring [QUEUE_DEPTH];
		int         ring_head;
		int         ring_tail;
		bit         pending;
		bit         burst;
		bit         watch;
		result_t    replies_due [$];
		int         errors;
		int         n_items;
		int         n_replies;
		int         n_sci;
		int         n_dropped;

		function new();
			foreach (ec_mem[i]) ec_mem[i] = '0;
			foreach (ring[i]) ring[i] = '0;
			cur_cmd    = '0;
			byte_count = '0;
			wr_addr    = '0;
		endfunction

		function void set_mode(bit m);
			acpi_en = m;
		endfunction

		function void note_item(item_t it);
			result_t r;
			int      nxt;
			r = '0;
			n_items++;
			case (it.opcode)
				OP_COMMAND: begin
					cur_cmd    = it.byte_value;
					byte_count = '0;
					case (it.byte_value)
						CMD_READ, CMD_WRITE: begin
							r.sci_pulse = 1'b1;
							byte_count  = (it.byte_value == CMD_READ) ? BYTES_READ : BYTES_WRITE;
							if (acpi_en && !burst) watch = 1'b1;
						end
						CMD_BURST_ON: begin
							burst         = 1'b1;
							watch         = 1'b1;
							r.reply_valid = 1'b1;
							r.reply_byte  = BURST_ACK;
							r.sci_pulse   = 1'b1;
						end
						CMD_BURST_OFF: begin
							burst       = 1'b0;
							watch       = 1'b0;
							r.sci_pulse = 1'b1;
						end
						CMD_QUERY: begin
							if (ring_head != ring_tail) begin
								r.reply_valid = 1'b1;
								r.reply_byte  = ring[ring_tail];
								r.sci_pulse   = 1'b1;
								ring_tail     = (ring_tail + 1) % QUEUE_DEPTH;
								if (ring_tail == ring_head) pending = 1'b0;
							end else begin
								pending = 1'b0;
							end
						end
						default: ;
					endcase
				end
				OP_DATA: begin
					if (byte_count != 2'd0) begin
						byte_count = byte_count - 2'd1;
						if (cur_cmd == CMD_READ) begin
							if (byte_count == 2'd0) begin
								r.reply_valid = 1'b1;
								r.reply_byte  = ec_mem[it.byte_value];
								r.sci_pulse   = 1'b1;
								watch         = 1'b0;
							end
						end else if (cur_cmd == CMD_WRITE) begin
							r.sci_pulse = 1'b1;
							// first byte is the address, second the data
							if (byte_count == 2'd1) begin
								wr_addr = it.byte_value;
							end else if (byte_count == 2'd0) begin
								ec_mem[wr_addr] = it.byte_value;
								watch           = 1'b0;
							end
						end
					end
				end
				OP_EVENT: begin
					ring[ring_head] = it.byte_value;
					nxt = (ring_head + 1) % QUEUE_DEPTH;
					if (nxt != ring_tail) ring_head = nxt;
					else n_dropped++;
					// flag and sci follow even a dropped push
					if (it.host_awake) begin
						pending     = 1'b1;
						r.sci_pulse = 1'b1;
					end
				end
				default: begin
					if (burst || watch) begin
						burst       = 1'b0;
						watch       = 1'b0;
						r.sci_pulse = 1'b1;
					end
				end
			endcase
			r.event_pending = pending;
			r.burst_active  = burst;
			r.burst_watch   = watch;
			if (r.reply_valid) n_replies++;
			if (r.sci_pulse) n_sci++;
			replies_due.push_back(r);
		endfunction

		function void check_field(string name, logic [7:0] want, logic [7:0] got);
			if (got !== want) begin
				$error("%s: expected %0h, got %0h", name, want, got);
				errors++;
			end
		endfunction

		function void check_result(result_t got);
			result_t want;
			if (replies_due.size() == 0) begin
				$error("result %h arrived with nothing outstanding", got);
				errors++;
				return;
			end
			want = replies_due.pop_front();
			check_field("reply_valid", want.reply_valid, got.reply_valid);
			check_field("reply_byte", want.reply_byte, got.reply_byte);
			check_field("sci_pulse", want.sci_pulse, got.sci_pulse);
			check_field("event_pending", want.event_pending, got.event_pending);
			check_field("burst_active", want.burst_active, got.burst_active);
			check_field("burst_watch", want.burst_watch, got.burst_watch);
		endfunction
	endclass

	logic               clk;
	logic               arst_n    = 1'b0;
	logic               cmd_valid = 1'b0;
	logic               cmd_stall;
	item_t              cmd       = '0;
	logic               res_valid;
	logic               res_stall = 1'b0;
	result_t            res;
	logic               psel      = 1'b0;
	logic               penable   = 1'b0;
	logic               pwrite    = 1'b0;
	logic [PADDR_W-1:0] paddr     = '0;
	logic [PDATA_W-1:0] pwdata    = '0;
	logic [PDATA_W-1:0] prdata;
	logic               pready;

	host_scoreboard sb;
	int burst_left  = 20;
	int n_settings  = 1;
	int quiet_count = 0;
	int stall_left  = 0;
	int stall_mode  = 0;
	int stall_tick  = 0;

	acpi_ec_host_interface u_dut (
		.clk       (clk),
		.arst_n    (arst_n),
		.cmd_valid (cmd_valid),
		.cmd_stall (cmd_stall),
		.cmd       (cmd),
		.res_valid (res_valid),
		.res_stall (res_stall),
		.res       (res),
		.psel      (psel),
		.penable   (penable),
		.pwrite    (pwrite),
		.paddr     (paddr),
		.pwdata    (pwdata),
		.prdata    (prdata),
		.pready    (pready)
	);

	initial begin
		clk = 1'b0;
		forever #6 clk = ~clk;
	end

	function automatic item_t host_item(opcode_t op, logic [7:0] b, logic awake = 1'b1);
		return item_t'{opcode: op, byte_value: b, host_awake: awake};
	endfunction

	// present one item, hold it until taken, then maybe leave a gap
	task automatic send_item(item_t it);
		int gap;
		@(negedge clk);
		cmd_valid <= 1'b1;
		cmd       <= it;
		@(posedge clk);
		while (cmd_stall) @(posedge clk);
		sb.note_item(it);
		if (burst_left > 0) burst_left--;
		if (burst_left == 0) begin
			gap = $urandom_range(1, 8);
			@(negedge clk);
			cmd_valid <= 1'b0;
			repeat (gap - 1) @(negedge clk);
			burst_left = $urandom_range(1, 40);
		end
	endtask

	// hold off the host side until every outstanding result is back
	task automatic drain_results();
		@(negedge clk);
		cmd_valid <= 1'b0;
		while (sb.replies_due.size() != 0) @(posedge clk);
		repeat (4) @(negedge clk);
	endtask

	task automatic set_acpi_en(bit m);
		logic [PDATA_W-1:0] rd;
		@(negedge clk);
		psel    <= 1'b1;
		penable <= 1'b0;
		pwrite  <= 1'b1;
		paddr   <= PADDR_W'(4 * REG_ACPI_EN);
		pwdata  <= PDATA_W'(m);
		@(negedge clk);
		penable <= 1'b1;
		@(posedge clk);
		while (!pready) @(posedge clk);
		@(negedge clk);
		penable <= 1'b0;
		pwrite  <= 1'b0;
		@(negedge clk);
		penable <= 1'b1;
		@(posedge clk);
		while (!pready) @(posedge clk);
		rd = prdata;
		@(negedge clk);
		psel    <= 1'b0;
		penable <= 1'b0;
		sb.set_mode(m);
		n_settings++;
		if (rd[0] !== m) begin
			$error("acpi enable readback: expected %0d, got %0d", m, rd[0]);
			sb.errors++;
		end
	endtask

	// mostly well-formed host transactions, some truncated, some noise
	task automatic host_sequence();
		int         kind;
		int         n;
		logic [7:0] adr;
		kind = $urandom_range(0, 99);
		// a small address pool makes reads land on written bytes
		adr  = ($urandom_range(0, 1) != 0) ? 8'($urandom_range(0, 7)) : 8'($urandom);
		if (kind < 22) begin
			send_item(host_item(OP_COMMAND, CMD_READ));
			send_item(host_item(OP_DATA, adr));
		end else if (kind < 42) begin
			send_item(host_item(OP_COMMAND, CMD_WRITE));
			send_item(host_item(OP_DATA, adr));
			send_item(host_item(OP_DATA, 8'($urandom)));
		end else if (kind < 50) begin
			send_item(host_item(OP_COMMAND, CMD_BURST_ON));
		end else if (kind < 56) begin
			send_item(host_item(OP_COMMAND, CMD_BURST_OFF));
		end else if (kind < 68) begin
			n = $urandom_range(1, 8);
			repeat (n) send_item(host_item(OP_COMMAND, CMD_QUERY, 1'($urandom)));
		end else if (kind < 78) begin
			n = ($urandom_range(0, 3) == 0) ? $urandom_range(16, 20) : $urandom_range(1, 6);
			repeat (n) send_item(host_item(OP_EVENT, 8'($urandom), $urandom_range(0, 3) != 0));
		end else if (kind < 86) begin
			send_item(host_item(OP_TIMEOUT, 8'($urandom), 1'($urandom)));
		end else if (kind < 93) begin
			// command cut short by whatever comes next
			send_item(host_item(OP_COMMAND, ($urandom_range(0, 1) != 0) ? CMD_READ : CMD_WRITE));
			if ($urandom_range(0, 1) != 0) send_item(host_item(OP_DATA, adr));
		end else begin
			send_item(item_t'(11'($urandom)));
		end
	endtask

	// result stalls: free-flowing, random or periodic, changing every so often
	always @(negedge clk) begin
		if (stall_left == 0) begin
			stall_mode <= $urandom_range(0, 2);
			stall_left <= $urandom_range(20, 120);
		end else begin
			stall_left <= stall_left - 1;
		end
		case (stall_mode)
			0:       res_stall <= 1'b0;
			1:       res_stall <= ($urandom_range(0, 2) == 0);
			default: res_stall <= ((stall_tick % 7) < 3);
		endcase
		stall_tick <= stall_tick + 1;
	end

	always @(posedge clk) begin
		if (arst_n) begin
			if (res_valid && !res_stall) sb.check_result(res);
			if ((cmd_valid && !cmd_stall) || (res_valid && !res_stall)) begin
				quiet_count <= 0;
			end else begin
				quiet_count <= quiet_count + 1;
			end
			if (quiet_count >= WATCHDOG_LIMIT) begin
				$display("watchdog: no item moved for %0d cycles", quiet_count);
				$display("DONE: errors detected");
				$finish;
			end
		end
	end

	initial begin
		int target;
		bit modes [5];
		modes = '{1'b1, 1'b0, 1'b1, 1'b0, 1'b1};
		sb = new();
		repeat (3) @(posedge clk);
		@(negedge clk);
		arst_n <= 1'b1;

		// directed part, acpi enable at its reset value
		send_item(host_item(OP_DATA, 8'hFF));
		send_item(host_item(OP_TIMEOUT, 8'h00, 1'b0));
		send_item(host_item(OP_COMMAND, CMD_QUERY, 1'b0));
		send_item(host_item(OP_COMMAND, CMD_READ));
		send_item(host_item(OP_DATA, 8'h00));
		send_item(host_item(OP_COMMAND, CMD_WRITE));
		send_item(host_item(OP_DATA, 8'hFF));
		send_item(host_item(OP_DATA, 8'hFF));
		send_item(host_item(OP_COMMAND, CMD_READ));
		send_item(host_item(OP_DATA, 8'hFF));
		send_item(host_item(OP_EVENT, 8'h00, 1'b1));
		send_item(host_item(OP_EVENT, 8'hFF, 1'b0));
		send_item(host_item(OP_COMMAND, CMD_QUERY));
		send_item(host_item(OP_COMMAND, CMD_QUERY));
		send_item(host_item(OP_COMMAND, CMD_BURST_ON));
		send_item(host_item(OP_TIMEOUT, 8'hFF));
		send_item(host_item(OP_COMMAND, CMD_BURST_ON));
		send_item(host_item(OP_COMMAND, CMD_BURST_OFF));
		send_item(host_item(OP_COMMAND, 8'h00));
		send_item(host_item(OP_COMMAND, 8'hFF));
		send_item(host_item(OP_DATA, 8'h5A));
		// write aborted after its address, then a read of that address
		send_item(host_item(OP_COMMAND, CMD_WRITE));
		send_item(host_item(OP_DATA, 8'h10));
		send_item(host_item(OP_COMMAND, CMD_READ));
		send_item(host_item(OP_DATA, 8'h10));

		target = sb.n_items;
		foreach (modes[i]) begin
			drain_results();
			set_acpi_en(modes[i]);
			target += 90;
			while (sb.n_items < target) host_sequence();
		end

		drain_results();
		repeat (8) @(posedge clk);
		$display("covered %0d items over %0d acpi enable settings", sb.n_items, n_settings);
		$display("%0d reply bytes, %0d sci pulses, %0d pushes dropped on a full ring",
			sb.n_replies, sb.n_sci, sb.n_dropped);
		if (sb.errors == 0 && sb.replies_due.size() == 0) begin
			$display("DONE: 0 errors");
		end else begin
			$display("DONE: errors detected");
		end
		$finish;
	end

endmodule

### filelist.f
sv/aechi_pkg.sv
sv/aechi_ram.sv
sv/acpi_ec_host_interface.sv
sv/aechi_checker.sv
tb/tb_acpi_ec_host_interface.sv
